// ===== design/wisper_pixel_fusion_macros.svh =====
// Assertion helpers shared by the fusion block
`ifndef WISPER_PIXEL_FUSION_MACROS_SVH
`define WISPER_PIXEL_FUSION_MACROS_SVH

// Same-cycle implication, checked out of reset
`define WPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define WPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/wpf_pkg.sv =====
`timescale 1ns / 1ps
package wpf_pkg;

  // Field counts and widths
  localparam int NBAND_FIELDS  = 4;
  localparam int NLEVEL_FIELDS = 4;
  localparam int BIDX_W        = $clog2(NBAND_FIELDS);
  localparam int VAL_W         = 16;
  localparam int DET_W         = 18;
  localparam int REG_W         = 24;
  localparam int FRAC_W        = 16;
  localparam int SCALED_W      = VAL_W + REG_W;
  // Widest sum over the largest band count
  localparam int SUM_W         = SCALED_W + $clog2(NBAND_FIELDS);
  localparam int DSUM_W        = DET_W + $clog2(NLEVEL_FIELDS);

  localparam int IN_DATA_W     = NBAND_FIELDS * VAL_W + NLEVEL_FIELDS * DET_W;
  localparam int OUT_DATA_W    = NBAND_FIELDS * VAL_W;

  // Pipeline depth outside the divider
  localparam int FRONT_STG     = 3;
  localparam int BACK_STG      = 3;

  // Configuration map
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_WEIGHT_BASE = NBAND_FIELDS;
  localparam int CFG_REG_COUNT   = 2 * NBAND_FIELDS;
  localparam logic [REG_W-1:0] REG_RESET = 24'h010000;

  localparam int DEF_BANDS         = 4;
  localparam int DEF_DETAIL_LEVELS = 4;

  typedef logic [VAL_W-1:0]        val_t;
  typedef logic signed [DET_W-1:0] det_t;
  typedef logic [REG_W-1:0]        reg_t;

  // Per-pixel data that rides alongside the divider
  typedef struct packed {
    val_t [NBAND_FIELDS-1:0]    val;
    logic signed [DSUM_W-1:0]   dsum;
    logic                       zero;
  } side_t;

endpackage

// ===== design/wisper_pixel_fusion.sv =====
`timescale 1ns / 1ps
// Pan-sharpening pixel fusion: each pixel's band values are scaled by their gains,
// each band's share of the band mean (rounded Q.16) times its weight forms a term,
// and the term times the summed wavelet details is added to the band value, rounded
// and clamped to 16 bits. One pixel is accepted every cycle unless the output stalls
// a full pipeline. The restoring divider resolves one quotient bit per pipeline stage,
// QUO_W = clog2(BANDS*65536+1). A zero mean injects nothing and raises out_tuser.
// Stalls ripple back only through full stages. The user must write configuration
// (index 0..3 gains, 4..7 weights, Q8.16) only while idle; the block does not check.
module wisper_pixel_fusion #(
  parameter int BANDS         = wpf_pkg::DEF_BANDS,
  parameter int DETAIL_LEVELS = wpf_pkg::DEF_DETAIL_LEVELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // band_value_0..3 (16b each), detail_level_0..3 (18b signed each), low bits first
  input  logic [wpf_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // fused_band_0..3 (16b each), low bits first
  output logic [wpf_pkg::OUT_DATA_W-1:0]  out_tdata,
  // zero_mean_flag
  output logic                            out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wpf_pkg::REG_W-1:0]       cfg_data
);
  import wpf_pkg::*;
  `include "wisper_pixel_fusion_macros.svh"

  localparam int QUO_W = $clog2(BANDS * (1 << FRAC_W) + 1);
  localparam int NSTG  = FRONT_STG + QUO_W + BACK_STG;

  reg_t [NBAND_FIELDS-1:0]  gain_r, weight_r;
  val_t [NBAND_FIELDS-1:0]  in_val;
  det_t [NLEVEL_FIELDS-1:0] in_det;
  val_t [NBAND_FIELDS-1:0]  fused;
  logic [NBAND_FIELDS-1:0][SUM_W+QUO_W-1:0] div_n;
  logic [NBAND_FIELDS-1:0][QUO_W-1:0]       div_q;
  logic [SUM_W-1:0] div_d;
  side_t            front_side, div_side;
  logic [NSTG-1:0]  valid_r, en;
  logic             zero_flag;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NBAND_FIELDS; b++) begin
        gain_r[b]   <= REG_RESET;
        weight_r[b] <= REG_RESET;
      end
    end else if (cfg_valid) begin
      if (cfg_index < CFG_WEIGHT_BASE) begin
        gain_r[cfg_index[BIDX_W-1:0]] <= cfg_data;
      end else if (cfg_index < CFG_REG_COUNT) begin
        weight_r[BIDX_W'(cfg_index - CFG_WEIGHT_BASE)] <= cfg_data;
      end
    end
  end

  // Stage k advances unless it and every stage after it hold an item and out stalls
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      en[k] = out_tready || !(&(valid_r | ~({NSTG{1'b1}} << k)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) begin
        valid_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = valid_r[NSTG-1];

  // Unpack the input item
  always_comb begin
    for (int b = 0; b < NBAND_FIELDS; b++) begin
      in_val[b] = in_tdata[b*VAL_W +: VAL_W];
    end
    for (int l = 0; l < NLEVEL_FIELDS; l++) begin
      in_det[l] = in_tdata[NBAND_FIELDS*VAL_W + l*DET_W +: DET_W];
    end
  end

  wpf_front #(.BANDS(BANDS), .DETAIL_LEVELS(DETAIL_LEVELS), .QUO_W(QUO_W)) u_front (
    .clk    (clk),
    .en     (en[FRONT_STG-1:0]),
    .val_i  (in_val),
    .det_i  (in_det),
    .gain_i (gain_r),
    .n_o    (div_n),
    .d_o    (div_d),
    .side_o (front_side)
  );

  wpf_div #(.BANDS(BANDS), .QUO_W(QUO_W)) u_div (
    .clk    (clk),
    .en     (en[FRONT_STG +: QUO_W]),
    .n_i    (div_n),
    .d_i    (div_d),
    .side_i (front_side),
    .q_o    (div_q),
    .side_o (div_side)
  );

  wpf_back #(.BANDS(BANDS), .QUO_W(QUO_W)) u_back (
    .clk      (clk),
    .en       (en[NSTG-1 -: BACK_STG]),
    .q_i      (div_q),
    .weight_i (weight_r),
    .side_i   (div_side),
    .fused_o  (fused),
    .zero_o   (zero_flag)
  );

  // Pack the result item
  always_comb begin
    for (int b = 0; b < NBAND_FIELDS; b++) begin
      out_tdata[b*VAL_W +: VAL_W] = fused[b];
    end
  end
  assign out_tuser = zero_flag;

  // Checks
  `WPF_ASSERT_NOW(a_empty_out_ready, !out_tvalid, in_tready, "input blocked with empty output")
  `WPF_ASSERT_NEXT(a_accept_fills, in_tvalid && in_tready, valid_r[0], "accepted item lost at entry")
  `WPF_ASSERT_NOW(a_unused_band_zero, out_tvalid && (BANDS < NBAND_FIELDS), out_tdata[OUT_DATA_W-1 -: VAL_W] == '0, "unused band nonzero")

endmodule

// ===== design/wpf_front.sv =====
`timescale 1ns / 1ps
module wpf_front #(
  parameter int BANDS         = wpf_pkg::DEF_BANDS,
  parameter int DETAIL_LEVELS = wpf_pkg::DEF_DETAIL_LEVELS,
  parameter int QUO_W         = 19
) (
  input  logic                                                clk,
  input  logic [wpf_pkg::FRONT_STG-1:0]                       en,
  input  wpf_pkg::val_t [wpf_pkg::NBAND_FIELDS-1:0]           val_i,
  input  wpf_pkg::det_t [wpf_pkg::NLEVEL_FIELDS-1:0]          det_i,
  input  wpf_pkg::reg_t [wpf_pkg::NBAND_FIELDS-1:0]           gain_i,
  output logic [wpf_pkg::NBAND_FIELDS-1:0][wpf_pkg::SUM_W+QUO_W-1:0] n_o,
  output logic [wpf_pkg::SUM_W-1:0]                           d_o,
  output wpf_pkg::side_t                                      side_o
);
  import wpf_pkg::*;

  localparam int NW = SUM_W + QUO_W;

  logic [SCALED_W-1:0] scaled0_nxt [NBAND_FIELDS];
  logic [SCALED_W-1:0] scaled0_r   [NBAND_FIELDS];
  logic [SCALED_W-1:0] scaled1_r   [NBAND_FIELDS];
  logic signed [DSUM_W-1:0] dsum0_nxt;
  side_t side0_r, side1_r, side2_r;
  logic [SUM_W-1:0] sum1_nxt, sum1_r, d2_r;
  logic [NW-1:0] n2_nxt [NBAND_FIELDS];
  logic [NW-1:0] n2_r   [NBAND_FIELDS];

  // Stage 0: gain products and detail sum
  always_comb begin
    dsum0_nxt = '0;
    for (int l = 0; l < DETAIL_LEVELS; l++) begin
      dsum0_nxt = dsum0_nxt + DSUM_W'(det_i[l]);
    end
    for (int b = 0; b < NBAND_FIELDS; b++) begin
      if (b < BANDS) begin
        scaled0_nxt[b] = SCALED_W'(gain_i[b]) * SCALED_W'(val_i[b]);
      end else begin
        scaled0_nxt[b] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      scaled0_r    <= scaled0_nxt;
      side0_r.val  <= val_i;
      side0_r.dsum <= dsum0_nxt;
      side0_r.zero <= 1'b0;
    end
  end

  // Stage 1: sum of scaled bands
  always_comb begin
    sum1_nxt = '0;
    for (int b = 0; b < BANDS; b++) begin
      sum1_nxt = sum1_nxt + SUM_W'(scaled0_r[b]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      scaled1_r <= scaled0_r;
      sum1_r    <= sum1_nxt;
      side1_r   <= side0_r;
    end
  end

  // Stage 2: dividends scaled*BANDS*2^16 plus half the divisor for rounding
  always_comb begin
    for (int b = 0; b < NBAND_FIELDS; b++) begin
      if (b < BANDS) begin
        n2_nxt[b] = ((NW'(scaled1_r[b]) * NW'(BANDS)) << FRAC_W) + NW'(sum1_r >> 1);
      end else begin
        n2_nxt[b] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      n2_r         <= n2_nxt;
      d2_r         <= sum1_r;
      side2_r.val  <= side1_r.val;
      side2_r.dsum <= side1_r.dsum;
      side2_r.zero <= (sum1_r == '0);
    end
  end

  always_comb begin
    for (int b = 0; b < NBAND_FIELDS; b++) begin
      n_o[b] = n2_r[b];
    end
  end
  assign d_o    = d2_r;
  assign side_o = side2_r;

endmodule

// ===== design/wpf_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage, all bands in lockstep
module wpf_div #(
  parameter int BANDS = wpf_pkg::DEF_BANDS,
  parameter int QUO_W = 19
) (
  input  logic                                                clk,
  input  logic [QUO_W-1:0]                                    en,
  input  logic [wpf_pkg::NBAND_FIELDS-1:0][wpf_pkg::SUM_W+QUO_W-1:0] n_i,
  input  logic [wpf_pkg::SUM_W-1:0]                           d_i,
  input  wpf_pkg::side_t                                      side_i,
  output logic [wpf_pkg::NBAND_FIELDS-1:0][QUO_W-1:0]         q_o,
  output wpf_pkg::side_t                                      side_o
);
  import wpf_pkg::*;

  localparam int NW = SUM_W + QUO_W;

  // Partial remainder and a shifter that trades dividend bits for quotient bits
  logic [SUM_W-1:0] rem_r   [QUO_W][BANDS];
  logic [SUM_W-1:0] rem_nxt [QUO_W][BANDS];
  logic [QUO_W-1:0] sh_r    [QUO_W][BANDS];
  logic [QUO_W-1:0] sh_nxt  [QUO_W][BANDS];
  logic [SUM_W-1:0] d_r     [QUO_W];
  logic [SUM_W-1:0] d_in    [QUO_W];
  side_t            side_r  [QUO_W];
  side_t            side_in [QUO_W];

  always_comb begin
    logic [SUM_W-1:0] rem_in;
    logic [QUO_W-1:0] sh_in;
    logic [SUM_W:0]   trial;
    logic             ge;
    for (int s = 0; s < QUO_W; s++) begin
      if (s == 0) begin
        d_in[s]    = d_i;
        side_in[s] = side_i;
      end else begin
        d_in[s]    = d_r[s-1];
        side_in[s] = side_r[s-1];
      end
      for (int b = 0; b < BANDS; b++) begin
        if (s == 0) begin
          rem_in = n_i[b][NW-1:QUO_W];
          sh_in  = n_i[b][QUO_W-1:0];
        end else begin
          rem_in = rem_r[s-1][b];
          sh_in  = sh_r[s-1][b];
        end
        trial = {rem_in, sh_in[QUO_W-1]};
        ge    = (trial >= {1'b0, d_in[s]});
        rem_nxt[s][b] = ge ? SUM_W'(trial - {1'b0, d_in[s]}) : trial[SUM_W-1:0];
        sh_nxt[s][b]  = {sh_in[QUO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QUO_W; s++) begin
      if (en[s]) begin
        rem_r[s]  <= rem_nxt[s];
        sh_r[s]   <= sh_nxt[s];
        d_r[s]    <= d_in[s];
        side_r[s] <= side_in[s];
      end
    end
  end

  // Quotients leave from the last stage; unused bands read zero
  always_comb begin
    for (int b = 0; b < NBAND_FIELDS; b++) begin
      if (b < BANDS) begin
        q_o[b] = sh_r[QUO_W-1][b];
      end else begin
        q_o[b] = '0;
      end
    end
  end
  assign side_o = side_r[QUO_W-1];

endmodule

// ===== design/wpf_back.sv =====
`timescale 1ns / 1ps
module wpf_back #(
  parameter int BANDS = wpf_pkg::DEF_BANDS,
  parameter int QUO_W = 19
) (
  input  logic                                        clk,
  input  logic [wpf_pkg::BACK_STG-1:0]                en,
  input  logic [wpf_pkg::NBAND_FIELDS-1:0][QUO_W-1:0] q_i,
  input  wpf_pkg::reg_t [wpf_pkg::NBAND_FIELDS-1:0]   weight_i,
  input  wpf_pkg::side_t                              side_i,
  output wpf_pkg::val_t [wpf_pkg::NBAND_FIELDS-1:0]   fused_o,
  output logic                                        zero_o
);
  import wpf_pkg::*;

  localparam int PROD_W = QUO_W + REG_W;
  localparam int TERM_W = PROD_W + 1 - FRAC_W;
  localparam int MUL_W  = TERM_W + 1 + DSUM_W;
  localparam int ACC_W  = MUL_W + 1;
  localparam int HI_W   = ACC_W - FRAC_W;
  localparam logic [PROD_W:0] PROD_HALF = (PROD_W+1)'(1) << (FRAC_W - 1);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_W - 1);

  logic [PROD_W-1:0]        prod_r  [NBAND_FIELDS];
  logic signed [MUL_W-1:0]  tdp_nxt [NBAND_FIELDS];
  logic signed [MUL_W-1:0]  tdp_r   [NBAND_FIELDS];
  val_t                     fused_nxt [NBAND_FIELDS];
  val_t                     fused_r   [NBAND_FIELDS];
  side_t                    side_a_r, side_b_r;
  logic                     zero_r;

  // Stage A: share times injection weight
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int b = 0; b < NBAND_FIELDS; b++) begin
        prod_r[b] <= PROD_W'(q_i[b]) * PROD_W'(weight_i[b]);
      end
      side_a_r <= side_i;
    end
  end

  // Stage B: round the term, multiply by the detail sum
  always_comb begin
    logic [PROD_W:0]   pr;
    logic [TERM_W-1:0] term;
    for (int b = 0; b < NBAND_FIELDS; b++) begin
      pr   = {1'b0, prod_r[b]} + PROD_HALF;
      term = pr[PROD_W:FRAC_W];
      tdp_nxt[b] = MUL_W'($signed({1'b0, term})) * MUL_W'($signed(side_a_r.dsum));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      tdp_r    <= tdp_nxt;
      side_b_r <= side_a_r;
    end
  end

  // Stage C: add to the band value, round and clamp
  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic [HI_W-1:0]         hi;
    for (int b = 0; b < NBAND_FIELDS; b++) begin
      acc = ACC_W'($signed({1'b0, side_b_r.val[b], FRAC_W'(0)})) + ACC_HALF;
      if (!side_b_r.zero) begin
        acc = acc + ACC_W'(tdp_r[b]);
      end
      hi = acc[ACC_W-1:FRAC_W];
      if (b >= BANDS || acc[ACC_W-1]) begin
        fused_nxt[b] = '0;
      end else if (|hi[HI_W-1:VAL_W]) begin
        fused_nxt[b] = '1;
      end else begin
        fused_nxt[b] = hi[VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      fused_r <= fused_nxt;
      zero_r  <= side_b_r.zero;
    end
  end

  always_comb begin
    for (int b = 0; b < NBAND_FIELDS; b++) begin
      fused_o[b] = fused_r[b];
    end
  end
  assign zero_o = zero_r;

endmodule

// ===== test/wisper_pixel_fusion_tb.sv =====
`timescale 1ns / 1ps
module wisper_pixel_fusion_tb;
  import wpf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RAND_PHASES    = 5;
  localparam int RAND_PER_PHASE = 180;

  // Register map, index by name
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_0   = 4'd0,
    REG_WEIGHT_0 = 4'd4,
    REG_UNMAPPED = 4'd15
  } reg_idx_e;

  // Link pacing modes
  typedef enum int {
    PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH
  } pace_e;

  typedef struct packed {
    logic signed [NLEVEL_FIELDS-1:0][DET_W-1:0] det;
    logic [NBAND_FIELDS-1:0][VAL_W-1:0]         val;
  } pixel_t;

  typedef struct packed {
    logic                               zero;
    logic [NBAND_FIELDS-1:0][VAL_W-1:0] band;
  } fused_t;

  typedef struct {
    pixel_t px;
    logic   known;
    fused_t fused;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [REG_W-1:0]      cfg_data;

  reg_t   gain_sh[NBAND_FIELDS];
  reg_t   weight_sh[NBAND_FIELDS];
  fused_t fused_q[$];
  pace_e  pace;
  int     errors;
  int     quiet_cycles;

  always #10 clk = ~clk;

  wisper_pixel_fusion DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Fused pixel from the shadow gains and weights
  function automatic fused_t fuse_pixel(pixel_t px);
    longint unsigned scaled[NBAND_FIELDS];
    longint unsigned total;
    longint unsigned share;
    longint          term;
    longint          dsum;
    longint          acc;
    fused_t          r;
    total = 0;
    dsum = 0;
    for (int i = 0; i < NBAND_FIELDS; i++) begin
      scaled[i] = longint'(gain_sh[i]) * longint'(px.val[i]);
      total += scaled[i];
      dsum += longint'($signed(px.det[i]));
    end
    r.zero = (total == 0);
    for (int i = 0; i < NBAND_FIELDS; i++) begin
      acc = longint'(px.val[i]) << FRAC_W;
      if (!r.zero) begin
        share = (scaled[i] * NBAND_FIELDS * 65536 + total / 2) / total;
        term = longint'((share * weight_sh[i] + 32768) >> FRAC_W);
        acc += term * dsum;
      end
      acc += 32768;
      if (acc < 0) r.band[i] = '0;
      else if ((acc >>> FRAC_W) > 65535) r.band[i] = 16'hFFFF;
      else r.band[i] = acc[31:16];
    end
    return r;
  endfunction

  // Register write on the config channel, shadow follows
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, reg_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < CFG_WEIGHT_BASE) gain_sh[idx] = value;
    else if (idx < CFG_REG_COUNT) weight_sh[idx - CFG_WEIGHT_BASE] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (fused_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(reg_t g[NBAND_FIELDS], reg_t w[NBAND_FIELDS]);
    wait_idle();
    for (int i = 0; i < NBAND_FIELDS; i++) begin
      write_reg(CFG_IDX_W'(REG_GAIN_0 + i), g[i]);
      write_reg(CFG_IDX_W'(REG_WEIGHT_0 + i), w[i]);
    end
  endtask

  // One pixel in; called at a falling edge, returns at a falling edge
  task automatic send_pixel(pixel_t px, logic known, fused_t want);
    int idle_pct;
    idle_pct = (pace == PACE_SRC_IDLE) ? 57 : (pace == PACE_BOTH) ? 11 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    fused_q.insert(fused_q.size(), known ? want : fuse_pixel(px));
    @(negedge clk);
  endtask

  function automatic logic signed [DET_W-1:0] rand_detail();
    case ($urandom_range(3))
      0: return DET_W'($urandom);
      1: return DET_W'(int'($urandom_range(1024)) - 512);
      2: return $urandom_range(1) ? 18'sh1FFFF : 18'sh20000;
      default: return '0;
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    for (int i = 0; i < NBAND_FIELDS; i++) begin
      case ($urandom_range(5))
        0: px.val[i] = '0;
        1: px.val[i] = 16'hFFFF;
        default: px.val[i] = VAL_W'($urandom);
      endcase
      px.det[i] = rand_detail();
    end
    return px;
  endfunction

  function automatic reg_t rand_reg();
    case ($urandom_range(5))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return REG_RESET;
      3: return REG_W'($urandom);
      default: return REG_W'($urandom_range(24'h040000));
    endcase
  endfunction

  // Sink back-pressure
  always @(negedge clk) begin
    if (pace == PACE_SINK_STALL) out_tready <= ($urandom_range(99) >= 57);
    else if (pace == PACE_BOTH) out_tready <= ($urandom_range(99) >= 11);
    else out_tready <= 1'b1;
  end

  // Result check against the oldest pending pixel
  always @(posedge clk) begin
    fused_t got;
    fused_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.band = out_tdata;
      got.zero = out_tuser;
      if (fused_q.size() == 0) begin
        $display("%t: unexpected result %h flag %b", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = fused_q.pop_front();
        for (int i = 0; i < NBAND_FIELDS; i++)
          if (got.band[i] !== want.band[i]) begin
            $display("%t: fused_band_%0d expected %h actual %h",
                     $time, i, want.band[i], got.band[i]);
            errors++;
          end
        if (got.zero !== want.zero) begin
          $display("%t: zero_mean_flag expected %b actual %b", $time, want.zero, got.zero);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    vector_t vectors[$];
    vector_t v;
    fused_t  none;
    reg_t    g[NBAND_FIELDS];
    reg_t    w[NBAND_FIELDS];
    errors = 0;
    quiet_cycles = 0;
    pace = PACE_FULL;
    none = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < NBAND_FIELDS; i++) begin
      gain_sh[i] = REG_RESET;
      weight_sh[i] = REG_RESET;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, reset gains and weights of 1.0
    // all-zero pixel: zero mean, nothing injected
    v.px = '0; v.known = 1; v.fused = none; v.fused.zero = 1;
    vectors.insert(vectors.size(), v);
    // zero details: outputs equal band values
    v.px = '0; v.px.val = {16'hFFFF, 16'h0001, 16'h8000, 16'h1234};
    v.fused = '0; v.fused.band = v.px.val; vectors.insert(vectors.size(), v);
    v.px.val = {4{16'hFFFF}}; v.fused.band = v.px.val; vectors.insert(vectors.size(), v);
    // zero mean ignores detail of either extreme
    v.px = '0; v.px.det = {4{18'sh1FFFF}};
    v.fused = none; v.fused.zero = 1; vectors.insert(vectors.size(), v);
    v.px.det = {4{18'sh20000}}; vectors.insert(vectors.size(), v);
    // extremes of detail, clamp both ways
    v.known = 0;
    v.px.val = {4{16'h8000}}; v.px.det = {4{18'sh1FFFF}}; vectors.insert(vectors.size(), v);
    v.px.det = {4{18'sh20000}}; vectors.insert(vectors.size(), v);
    v.px.val = {16'h0000, 16'h0000, 16'h0000, 16'h0001}; vectors.insert(vectors.size(), v);
    v.px.det = {4{18'sh1FFFF}}; vectors.insert(vectors.size(), v);
    v.px.val = {16'h0010, 16'h0020, 16'h0030, 16'h0040};
    v.px.det = {18'sh00003, -18'sh00005, 18'sh00007, 18'sh00001};
    vectors.insert(vectors.size(), v);
    v.px.det = {18'sh3FFFF, 18'sh00000, 18'sh00001, 18'sh20001};
    vectors.insert(vectors.size(), v);
    v.px.val = {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
    v.px.det = {18'sh00100, 18'sh00200, -18'sh00050, 18'sh0AAAA};
    vectors.insert(vectors.size(), v);
    v.px.val = {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555};
    v.px.det = {18'sh15555, 18'sh2AAAA, 18'sh15555, 18'sh2AAAA};
    vectors.insert(vectors.size(), v);
    foreach (vectors[k]) send_pixel(vectors[k].px, vectors[k].known, vectors[k].fused);
    in_tvalid <= 1'b0;

    // Unmapped index must leave the map alone
    wait_idle();
    write_reg(REG_UNMAPPED, 24'h000000);
    for (int k = 0; k < 4; k++) send_pixel(rand_pixel(), 0, none);
    in_tvalid <= 1'b0;

    // Zero gains: every pixel hits the zero-mean path
    for (int i = 0; i < NBAND_FIELDS; i++) begin g[i] = '0; w[i] = 24'hFFFFFF; end
    load_config(g, w);
    v.px = '0; v.px.val = {16'h0001, 16'hFFFF, 16'h7FFF, 16'h0100};
    v.px.det = {4{18'sh1FFFF}};
    v.fused = '0; v.fused.band = v.px.val; v.fused.zero = 1;
    send_pixel(v.px, 1, v.fused);
    for (int k = 0; k < 6; k++) send_pixel(rand_pixel(), 0, none);
    in_tvalid <= 1'b0;

    // Random phases, each with its own register set; pacing cycles through the four modes
    for (int p = 0; p < RAND_PHASES; p++) begin
      for (int i = 0; i < NBAND_FIELDS; i++) begin
        case (p)
          0: begin g[i] = 24'hFFFFFF; w[i] = 24'hFFFFFF; end
          1: begin g[i] = REG_RESET; w[i] = '0; end
          default: begin g[i] = rand_reg(); w[i] = rand_reg(); end
        endcase
      end
      load_config(g, w);
      pace = pace_e'(p % 4);
      for (int k = 0; k < RAND_PER_PHASE; k++) send_pixel(rand_pixel(), 0, none);
      in_tvalid <= 1'b0;
    end

    wait_idle();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
